// ===== hw/rtl/segint_pkg.sv =====
// Shared types and constants of the segment intersection core.
package segint_pkg;

   localparam int COORD_W = 24;

   typedef struct packed {
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic signed [COORD_W-1:0] p4_x;
      logic signed [COORD_W-1:0] p4_y;
   } seg_req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] cross_x;
      logic signed [COORD_W-1:0] cross_y;
   } seg_rsp_type;

   typedef struct packed {
      logic valid;
      logic hit;
      logic neg_x;
      logic neg_y;
   } seg_ctrl_type;

endpackage

// ===== hw/rtl/segint_front.sv =====
// Front end: coordinate differences, cross products and the three determinants.
module segint_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   up_valid,
   input  segint_pkg::seg_req_type                up_data,
   output logic                                   dn_valid,
   output logic signed [2*segint_pkg::COORD_W+2:0] dn_d,
   output logic signed [2*segint_pkg::COORD_W+2:0] dn_un,
   output logic signed [2*segint_pkg::COORD_W+2:0] dn_vn,
   output logic signed [segint_pkg::COORD_W:0]     dn_ax,
   output logic signed [segint_pkg::COORD_W:0]     dn_ay,
   output logic signed [segint_pkg::COORD_W-1:0]   dn_x1,
   output logic signed [segint_pkg::COORD_W-1:0]   dn_y1
);
   localparam int W   = segint_pkg::COORD_W;
   localparam int DFW = W + 1;
   localparam int PW  = 2 * DFW;
   localparam int XW  = PW + 1;

   logic                  v1_ff, v2_ff, v3_ff;
   logic signed [DFW-1:0] ax1_ff, ay1_ff, bx1_ff, by1_ff, cx1_ff, cy1_ff;
   logic signed [DFW-1:0] ax1_in, ay1_in, bx1_in, by1_in, cx1_in, cy1_in;
   logic signed [W-1:0]   x1_1_ff, y1_1_ff, x1_2_ff, y1_2_ff, x1_3_ff, y1_3_ff;
   logic signed [DFW-1:0] ax2_ff, ay2_ff, ax3_ff, ay3_ff;
   logic signed [PW-1:0]  p_axby_ff, p_aybx_ff, p_cxby_ff, p_cybx_ff, p_cxay_ff, p_cyax_ff;
   logic signed [XW-1:0]  d_ff, un_ff, vn_ff;

   assign ax1_in = {up_data.p2_x[W-1], up_data.p2_x} - {up_data.p1_x[W-1], up_data.p1_x};
   assign ay1_in = {up_data.p2_y[W-1], up_data.p2_y} - {up_data.p1_y[W-1], up_data.p1_y};
   assign bx1_in = {up_data.p4_x[W-1], up_data.p4_x} - {up_data.p3_x[W-1], up_data.p3_x};
   assign by1_in = {up_data.p4_y[W-1], up_data.p4_y} - {up_data.p3_y[W-1], up_data.p3_y};
   assign cx1_in = {up_data.p3_x[W-1], up_data.p3_x} - {up_data.p1_x[W-1], up_data.p1_x};
   assign cy1_in = {up_data.p3_y[W-1], up_data.p3_y} - {up_data.p1_y[W-1], up_data.p1_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= up_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff    <= ax1_in;
         ay1_ff    <= ay1_in;
         bx1_ff    <= bx1_in;
         by1_ff    <= by1_in;
         cx1_ff    <= cx1_in;
         cy1_ff    <= cy1_in;
         x1_1_ff   <= up_data.p1_x;
         y1_1_ff   <= up_data.p1_y;

         p_axby_ff <= PW'(ax1_ff) * PW'(by1_ff);
         p_aybx_ff <= PW'(ay1_ff) * PW'(bx1_ff);
         p_cxby_ff <= PW'(cx1_ff) * PW'(by1_ff);
         p_cybx_ff <= PW'(cy1_ff) * PW'(bx1_ff);
         p_cxay_ff <= PW'(cx1_ff) * PW'(ay1_ff);
         p_cyax_ff <= PW'(cy1_ff) * PW'(ax1_ff);
         ax2_ff    <= ax1_ff;
         ay2_ff    <= ay1_ff;
         x1_2_ff   <= x1_1_ff;
         y1_2_ff   <= y1_1_ff;

         d_ff      <= XW'(p_axby_ff) - XW'(p_aybx_ff);
         un_ff     <= XW'(p_cxby_ff) - XW'(p_cybx_ff);
         vn_ff     <= XW'(p_cxay_ff) - XW'(p_cyax_ff);
         ax3_ff    <= ax2_ff;
         ay3_ff    <= ay2_ff;
         x1_3_ff   <= x1_2_ff;
         y1_3_ff   <= y1_2_ff;
      end
   end

   assign dn_valid = v3_ff;
   assign dn_d     = d_ff;
   assign dn_un    = un_ff;
   assign dn_vn    = vn_ff;
   assign dn_ax    = ax3_ff;
   assign dn_ay    = ay3_ff;
   assign dn_x1    = x1_3_ff;
   assign dn_y1    = y1_3_ff;

endmodule

// ===== hw/rtl/segint_scale.sv =====
// Hit test, magnitudes and the numerators u*|delta| for the divider chain.
module segint_scale (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   up_valid,
   input  logic signed [2*segint_pkg::COORD_W+2:0] up_d,
   input  logic signed [2*segint_pkg::COORD_W+2:0] up_un,
   input  logic signed [2*segint_pkg::COORD_W+2:0] up_vn,
   input  logic signed [segint_pkg::COORD_W:0]     up_ax,
   input  logic signed [segint_pkg::COORD_W:0]     up_ay,
   input  logic signed [segint_pkg::COORD_W-1:0]   up_x1,
   input  logic signed [segint_pkg::COORD_W-1:0]   up_y1,
   output segint_pkg::seg_ctrl_type                dn_ctrl,
   output logic [2*segint_pkg::COORD_W:0]          dn_d,
   output logic [2*segint_pkg::COORD_W:0]          dn_rx,
   output logic [segint_pkg::COORD_W-1:0]          dn_nx,
   output logic [2*segint_pkg::COORD_W:0]          dn_ry,
   output logic [segint_pkg::COORD_W-1:0]          dn_ny,
   output logic [2*segint_pkg::COORD_W-1:0]        dn_side
);
   localparam int W   = segint_pkg::COORD_W;
   localparam int DFW = W + 1;
   localparam int XW  = 2 * DFW + 1;
   localparam int MW  = 2 * W + 1;
   localparam int LW  = W + 1;
   localparam int HW  = MW - LW;
   localparam int NW  = 3 * W + 1;

   logic [XW-1:0]  d_abs, un_abs, vn_abs;
   logic           un_ok, vn_ok;
   segint_pkg::seg_ctrl_type c4_in, c4_ff, c5_ff, c6_ff;
   logic [MW-1:0]  dm4_ff, um4_ff, dm5_ff, dm6_ff;
   logic [W-1:0]   axm4_ff, aym4_ff;
   logic [DFW-1:0] axm_in, aym_in;
   logic [2*W-1:0] side4_ff, side5_ff, side6_ff;
   logic [LW+W-1:0] pxl_ff, pyl_ff;
   logic [HW+W-1:0] pxh_ff, pyh_ff;
   logic [NW-1:0]  nx6_ff, ny6_ff;

   assign d_abs  = up_d[XW-1]  ? XW'(-up_d)  : up_d;
   assign un_abs = up_un[XW-1] ? XW'(-up_un) : up_un;
   assign vn_abs = up_vn[XW-1] ? XW'(-up_vn) : up_vn;
   assign axm_in = up_ax[DFW-1] ? DFW'(-up_ax) : up_ax;
   assign aym_in = up_ay[DFW-1] ? DFW'(-up_ay) : up_ay;

   assign un_ok = (up_un == '0) || ((up_un[XW-1] == up_d[XW-1]) && (un_abs <= d_abs));
   assign vn_ok = (up_vn == '0) || ((up_vn[XW-1] == up_d[XW-1]) && (vn_abs <= d_abs));

   always_comb begin
      c4_in.valid = up_valid;
      c4_in.hit   = (up_d != '0) && un_ok && vn_ok;
      c4_in.neg_x = (up_un[XW-1] ^ up_d[XW-1]) ^ up_ax[DFW-1];
      c4_in.neg_y = (up_un[XW-1] ^ up_d[XW-1]) ^ up_ay[DFW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (en) begin
         c4_ff <= c4_in;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm4_ff   <= d_abs[MW-1:0];
         um4_ff   <= un_abs[MW-1:0];
         axm4_ff  <= axm_in[W-1:0];
         aym4_ff  <= aym_in[W-1:0];
         side4_ff <= {up_x1, up_y1};

         pxl_ff   <= (LW+W)'(um4_ff[LW-1:0]) * (LW+W)'(axm4_ff);
         pyl_ff   <= (LW+W)'(um4_ff[LW-1:0]) * (LW+W)'(aym4_ff);
         pxh_ff   <= (HW+W)'(um4_ff[MW-1:LW]) * (HW+W)'(axm4_ff);
         pyh_ff   <= (HW+W)'(um4_ff[MW-1:LW]) * (HW+W)'(aym4_ff);
         dm5_ff   <= dm4_ff;
         side5_ff <= side4_ff;

         nx6_ff   <= NW'(pxl_ff) + (NW'(pxh_ff) << LW);
         ny6_ff   <= NW'(pyl_ff) + (NW'(pyh_ff) << LW);
         dm6_ff   <= dm5_ff;
         side6_ff <= side5_ff;
      end
   end

   assign dn_ctrl = c6_ff;
   assign dn_d    = dm6_ff;
   assign dn_rx   = nx6_ff[NW-1:W];
   assign dn_nx   = nx6_ff[W-1:0];
   assign dn_ry   = ny6_ff[NW-1:W];
   assign dn_ny   = ny6_ff[W-1:0];
   assign dn_side = side6_ff;

endmodule

// ===== hw/rtl/segint_div_cell.sv =====
// One restoring division cell: one quotient bit per lane, x and y sharing the divisor.
module segint_div_cell #(
   parameter int MW = 49,
   parameter int QW = 24,
   parameter int SW = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  segint_pkg::seg_ctrl_type up_ctrl,
   input  logic [MW-1:0]            up_d,
   input  logic [MW-1:0]            up_rx,
   input  logic [QW-1:0]            up_nx,
   input  logic [MW-1:0]            up_ry,
   input  logic [QW-1:0]            up_ny,
   input  logic [SW-1:0]            up_side,
   output segint_pkg::seg_ctrl_type dn_ctrl,
   output logic [MW-1:0]            dn_d,
   output logic [MW-1:0]            dn_rx,
   output logic [QW-1:0]            dn_nx,
   output logic [MW-1:0]            dn_ry,
   output logic [QW-1:0]            dn_ny,
   output logic [SW-1:0]            dn_side
);
   logic [MW:0]   tx, ty, dd;
   logic          gex, gey;
   logic [MW:0]   sx, sy;
   segint_pkg::seg_ctrl_type ctrl_ff;
   logic [MW-1:0] d_ff, rx_ff, ry_ff, rx_in, ry_in;
   logic [QW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [SW-1:0] side_ff;

   assign dd  = {1'b0, up_d};
   assign tx  = {up_rx, up_nx[QW-1]};
   assign ty  = {up_ry, up_ny[QW-1]};
   assign gex = tx >= dd;
   assign gey = ty >= dd;
   assign sx  = gex ? tx - dd : tx;
   assign sy  = gey ? ty - dd : ty;

   assign rx_in = sx[MW-1:0];
   assign ry_in = sy[MW-1:0];
   assign nx_in = {up_nx[QW-2:0], gex};
   assign ny_in = {up_ny[QW-2:0], gey};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= up_d;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         side_ff <= up_side;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_d    = d_ff;
   assign dn_rx   = rx_ff;
   assign dn_nx   = nx_ff;
   assign dn_ry   = ry_ff;
   assign dn_ny   = ny_ff;
   assign dn_side = side_ff;

endmodule

// ===== hw/rtl/segment_intersection_core.sv =====
// Segment intersection core: pipeline front end, scaler, divider cell chain, output register.
// Stages from an accepted item to its result: 3 front, 3 scaler, 24 divider cells
// and 1 output register; a result-side stall with a result held freezes the whole pipeline.
// Throughput: one item per cycle unless stalled; each divider cell retires one quotient bit.
// Reset: synchronous, clears all valid flags; no item is in flight after reset.
module segment_intersection_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  segint_pkg::seg_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output segint_pkg::seg_rsp_type rsp_data
);
   localparam int W   = segint_pkg::COORD_W;
   localparam int XW  = 2 * W + 3;
   localparam int MW  = 2 * W + 1;
   localparam int SW  = 2 * W;

   logic                  en;
   logic                  f_valid;
   logic signed [XW-1:0]  f_d, f_un, f_vn;
   logic signed [W:0]     f_ax, f_ay;
   logic signed [W-1:0]   f_x1, f_y1;

   segint_pkg::seg_ctrl_type chain_ctrl [0:W];
   logic [MW-1:0] chain_d  [0:W];
   logic [MW-1:0] chain_rx [0:W];
   logic [W-1:0]  chain_nx [0:W];
   logic [MW-1:0] chain_ry [0:W];
   logic [W-1:0]  chain_ny [0:W];
   logic [SW-1:0] chain_side [0:W];

   logic [W-1:0]  base_x, base_y, pos_x, pos_y;
   logic          rsp_valid_ff;
   segint_pkg::seg_rsp_type rsp_data_ff, rsp_data_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   segint_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (req_valid),
      .up_data  (req_data),
      .dn_valid (f_valid),
      .dn_d     (f_d),
      .dn_un    (f_un),
      .dn_vn    (f_vn),
      .dn_ax    (f_ax),
      .dn_ay    (f_ay),
      .dn_x1    (f_x1),
      .dn_y1    (f_y1)
   );

   segint_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (f_valid),
      .up_d     (f_d),
      .up_un    (f_un),
      .up_vn    (f_vn),
      .up_ax    (f_ax),
      .up_ay    (f_ay),
      .up_x1    (f_x1),
      .up_y1    (f_y1),
      .dn_ctrl  (chain_ctrl[0]),
      .dn_d     (chain_d[0]),
      .dn_rx    (chain_rx[0]),
      .dn_nx    (chain_nx[0]),
      .dn_ry    (chain_ry[0]),
      .dn_ny    (chain_ny[0]),
      .dn_side  (chain_side[0])
   );

   for (genvar i = 0; i < W; i++) begin : g_cell
      segint_div_cell #(
         .MW (MW),
         .QW (W),
         .SW (SW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_ctrl (chain_ctrl[i]),
         .up_d    (chain_d[i]),
         .up_rx   (chain_rx[i]),
         .up_nx   (chain_nx[i]),
         .up_ry   (chain_ry[i]),
         .up_ny   (chain_ny[i]),
         .up_side (chain_side[i]),
         .dn_ctrl (chain_ctrl[i+1]),
         .dn_d    (chain_d[i+1]),
         .dn_rx   (chain_rx[i+1]),
         .dn_nx   (chain_nx[i+1]),
         .dn_ry   (chain_ry[i+1]),
         .dn_ny   (chain_ny[i+1]),
         .dn_side (chain_side[i+1])
      );
   end

   assign base_x = chain_side[W][SW-1:W];
   assign base_y = chain_side[W][W-1:0];
   assign pos_x  = chain_ctrl[W].neg_x ? base_x - chain_nx[W] : base_x + chain_nx[W];
   assign pos_y  = chain_ctrl[W].neg_y ? base_y - chain_ny[W] : base_y + chain_ny[W];

   always_comb begin
      rsp_data_in.hit     = chain_ctrl[W].hit;
      rsp_data_in.cross_x = chain_ctrl[W].hit ? pos_x : '0;
      rsp_data_in.cross_y = chain_ctrl[W].hit ? pos_y : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain_ctrl[W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.hit |-> rsp_data_ff.cross_x == '0 && rsp_data_ff.cross_y == '0)
      else $error("miss item with non-zero point");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !chain_ctrl[W].valid)
      else $error("item present straight after reset");

   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(chain_ctrl[W]) && $stable(chain_nx[W]))
      else $error("divider chain moved during output stall");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      chain_ctrl[W].valid && chain_ctrl[W].hit |-> chain_rx[W] < chain_d[W])
      else $error("divider remainder not below divisor on hit item");
`endif

endmodule

// ===== sim/segment_intersection_core_tb.sv =====
// Testbench for the segment intersection core: directed and random segment pairs against a predictor.
module segment_intersection_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = segint_pkg::COORD_W;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   segint_pkg::seg_req_type req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   segint_pkg::seg_rsp_type rsp_data;

   segint_pkg::seg_rsp_type expected_points[$];
   int          error_count = 0;
   int          hit_count = 0;
   int          item_count = 0;
   bit          sink_hold = 1'b0;

   segment_intersection_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // exact predictor: integer cross products, quotient truncated toward zero
   function automatic segint_pkg::seg_rsp_type intersect_point(segint_pkg::seg_req_type s);
      segint_pkg::seg_rsp_type r;
      longint ax, ay, bx, by, cx, cy;
      logic signed [127:0] d, un, vn, tx, ty;
      r = '0;
      ax = longint'(s.p2_x) - longint'(s.p1_x);
      ay = longint'(s.p2_y) - longint'(s.p1_y);
      bx = longint'(s.p4_x) - longint'(s.p3_x);
      by = longint'(s.p4_y) - longint'(s.p3_y);
      cx = longint'(s.p3_x) - longint'(s.p1_x);
      cy = longint'(s.p3_y) - longint'(s.p1_y);
      d  = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
      if (d == 0) return r;
      un = 128'(cx) * 128'(by) - 128'(cy) * 128'(bx);
      vn = 128'(cx) * 128'(ay) - 128'(cy) * 128'(ax);
      if (d < 0) begin
         d = -d; un = -un; vn = -vn;
      end
      if (un < 0 || un > d || vn < 0 || vn > d) return r;
      tx = (un * 128'(ax)) / d;
      ty = (un * 128'(ay)) / d;
      r.hit = 1'b1;
      r.cross_x = CW'(longint'(s.p1_x) + longint'(tx));
      r.cross_y = CW'(longint'(s.p1_y) + longint'(ty));
      return r;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic send_pair(segint_pkg::seg_req_type s);
      int g;
      g = sink_hold ? 0 : gap_len();
      repeat (g) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      expected_points.push_back(intersect_point(s));
      item_count++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [CW-1:0] rnd_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(0, 2000)) - 1000);
         default: return CW'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   task automatic test_directed();
      localparam logic signed [CW-1:0] MX = {1'b0, {(CW-1){1'b1}}};
      localparam logic signed [CW-1:0] MN = {1'b1, {(CW-1){1'b0}}};
      // plain crossing
      send_pair('{0, 0, 512, 512, 0, 512, 512, 0});
      // parallel
      send_pair('{0, 0, 256, 0, 0, 256, 256, 256});
      // collinear overlap
      send_pair('{0, 0, 256, 0, 128, 0, 512, 0});
      // degenerate points
      send_pair('{5, 5, 5, 5, 5, 5, 5, 5});
      // touching at ends
      send_pair('{0, 0, 256, 0, 256, 0, 256, 256});
      send_pair('{0, 0, 256, 256, 0, 0, -256, 256});
      // T junction
      send_pair('{0, 0, 512, 0, 256, 0, 256, 300});
      // apart
      send_pair('{0, 0, 100, 100, 200, 0, 300, -100});
      // extremes
      send_pair('{MN, MN, MX, MX, MN, MX, MX, MN});
      send_pair('{MX, MN, MN, MX, MN, MN, MX, MX});
      send_pair('{MN, 0, MX, 0, 0, MN, 0, MX});
      send_pair('{MX, MX, MN, MN, MX, MN, MN, MX});
      send_pair('{-1, -1, -1, -1, -1, -1, -1, -1});
      // truncation with negative quotient
      send_pair('{0, 0, -7, -3, -1, 0, -1, -5});
      send_pair('{3, -1, -5, 7, -4, -6, 2, 9});
   endtask

   task automatic test_random();
      segint_pkg::seg_req_type s;
      int mode;
      repeat (840) begin
         mode = $urandom_range(0, 2);
         s.p1_x = rnd_coord(mode); s.p1_y = rnd_coord(mode);
         s.p2_x = rnd_coord(mode); s.p2_y = rnd_coord(mode);
         s.p3_x = rnd_coord(mode); s.p3_y = rnd_coord(mode);
         s.p4_x = rnd_coord(mode); s.p4_y = rnd_coord(mode);
         if ($urandom_range(0, 9) == 0) begin
            s.p3_x = s.p1_x; s.p3_y = s.p1_y;
         end
         if ($urandom_range(0, 15) == 0) begin
            s.p4_x = s.p3_x + (s.p2_x - s.p1_x);
            s.p4_y = s.p3_y + (s.p2_y - s.p1_y);
         end
         send_pair(s);
      end
   endtask

   // result side stall generator, occasional stretches without stalls
   initial begin
      int g;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            sink_hold = 1'b1;
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 80)) @(negedge clock);
            sink_hold = 1'b0;
         end
         g = gap_len();
         rsp_stall <= (g != 0);
         repeat (g == 0 ? 1 : g) @(negedge clock);
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      segint_pkg::seg_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_data);
            error_count++;
         end else begin
            e = expected_points.pop_front();
            if (e.hit) hit_count++;
            if (rsp_data.hit !== e.hit)
               $display("%0t: hit expected %b actual %b", $time, e.hit, rsp_data.hit);
            if (rsp_data.cross_x !== e.cross_x)
               $display("%0t: cross_x expected %0d actual %0d", $time, e.cross_x,
                        rsp_data.cross_x);
            if (rsp_data.cross_y !== e.cross_y)
               $display("%0t: cross_y expected %0d actual %0d", $time, e.cross_y,
                        rsp_data.cross_y);
            if (rsp_data !== e) error_count++;
         end
      end
   end

   initial begin
      #20ms;
      $display("segment_intersection_core_tb: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d segment pairs checked, %0d hits, with random stalls on both sides",
               item_count, hit_count);
      if (error_count == 0 && expected_points.size() == 0)
         $display("segment_intersection_core_tb: done, clean");
      else
         $display("segment_intersection_core_tb: done, errors");
      $finish;
   end

endmodule
